@@ rtl/deq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and codes for the ring-buffer deque: actions, result status,
// controller states and the command/status bundles between the two halves.
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int unsigned ActionWidth = 3;
  localparam int unsigned StatusWidth = 3;
  localparam int unsigned FieldWidth  = 32;

  typedef enum logic [ActionWidth-1:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_PEEK_FRONT = 3'd4,
    ACT_PEEK_BACK  = 3'd5,
    ACT_CLEAR      = 3'd6,
    ACT_EXIT       = 3'd7
  } deq_action_e;

  typedef enum logic [StatusWidth-1:0] {
    STS_OK      = 3'd0,
    STS_ELEMENT = 3'd1,
    STS_EMPTY   = 3'd2,
    STS_GOODBYE = 3'd3,
    STS_FULL    = 3'd4
  } deq_status_e;

  typedef enum logic {
    CTRL_IDLE,
    CTRL_OUT
  } deq_state_e;

  // controller to datapath
  typedef struct packed {
    logic exec;     // run the accepted command against the queue state
    logic capture;  // latch the result status
  } deq_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic halted;
  } deq_stat_t;

endpackage

@@ rtl/double_ended_queue_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue_unit
// Bounded double-ended queue in a ring store: push, pop and peek at either
// end, clear, and exit (no further results until reset).
// ----------------------------------------------------------------------------
//  channel  | handshake                | payload
//  ---------+--------------------------+------------------------------
//  command  | in_valid_i / in_stall_o  | action_i[2:0], value_i[31:0]
//  result   | out_valid_o / out_stall_i| status_o[2:0], element_o[31:0]
//
//  a command's transfer cycle runs the single-port store access and state
//  update; the next cycle shows the result
//  the input stays stalled until the result transfers
//  after reset the queue is empty; slots are not cleared, no clearing pass
//  after exit, commands still transfer in but produce no result
// ----------------------------------------------------------------------------
module double_ended_queue_unit #(
  parameter int unsigned DEPTH      = 1024,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  action_i,
  input  logic [31:0] value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [31:0] element_o
);

  deq_pkg::deq_cmd_t  cmd;
  deq_pkg::deq_stat_t stat;

  deq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  deq_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .action_i  (action_i),
    .value_i   (value_i),
    .status_o  (status_o),
    .element_o (element_o)
  );

  // one command in flight at a time
  a_no_overlap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(out_valid_o && !in_stall_o))
    else $error("input open while a result is pending");

  // a live command always yields a result next cycle
  a_result_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && !stat.halted) |=> out_valid_o)
    else $error("accepted command produced no result");

  // element word only travels with an element status
  a_element_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != deq_pkg::STS_ELEMENT) |-> (element_o == '0))
    else $error("nonzero element without element status");

  // goodbye leaves the block halted
  a_halt_after_exit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == deq_pkg::STS_GOODBYE) |-> stat.halted)
    else $error("goodbye reported but block not halted");

endmodule

@@ rtl/deq_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_ctrl
// Handshake controller: takes one command, holds the result until it is
// transferred, then opens the input again.
// ----------------------------------------------------------------------------
module deq_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  input  deq_pkg::deq_stat_t stat_i,
  output deq_pkg::deq_cmd_t  cmd_o
);

  deq_pkg::deq_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= deq_pkg::CTRL_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    in_stall_o   = 1'b1;
    out_valid_o  = 1'b0;
    cmd_o        = '0;
    case (state_q)
      deq_pkg::CTRL_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          // once halted, commands are swallowed without a result
          cmd_o.exec    = ~stat_i.halted;
          cmd_o.capture = ~stat_i.halted;
          if (!stat_i.halted) begin
            state_d = deq_pkg::CTRL_OUT;
          end
        end
      end
      deq_pkg::CTRL_OUT: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          state_d = deq_pkg::CTRL_IDLE;
        end
      end
      default: begin
        state_d = deq_pkg::CTRL_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/deq_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_datapath
// Ring store, front index, element count and halt flag, plus the result
// register. At most one store access per command.
// ----------------------------------------------------------------------------
module deq_datapath #(
  parameter int unsigned DEPTH      = 1024,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  deq_pkg::deq_cmd_t                   cmd_i,
  output deq_pkg::deq_stat_t                  stat_o,
  input  logic [deq_pkg::ActionWidth-1:0]     action_i,
  input  logic [deq_pkg::FieldWidth-1:0]      value_i,
  output logic [deq_pkg::StatusWidth-1:0]     status_o,
  output logic [deq_pkg::FieldWidth-1:0]      element_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [DATA_WIDTH-1:0] mem_q [DEPTH];
  logic [DATA_WIDTH-1:0] rd_data_q;

  logic [AW-1:0] front_q, front_d;
  logic [CW-1:0] count_q, count_d;
  logic          halted_q, halted_d;
  deq_pkg::deq_status_e status_q, status_d;

  logic          wr_en, rd_en;
  logic [AW-1:0] addr;
  logic [AW:0]   tail_sum, back_sum;
  logic [AW-1:0] tail_pos, back_pos;
  logic          full, empty;
  logic [63:0]   value_ext, rd_ext;

  assign full  = (count_q == CW'(DEPTH));
  assign empty = (count_q == '0);

  // slot just past the back, and the back itself, wrapped once
  assign tail_sum = (AW+1)'(front_q) + (AW+1)'(count_q);
  assign back_sum = tail_sum - (AW+1)'(1);
  assign tail_pos = (tail_sum >= (AW+1)'(DEPTH)) ? AW'(tail_sum - (AW+1)'(DEPTH))
                                                 : AW'(tail_sum);
  assign back_pos = (back_sum >= (AW+1)'(DEPTH)) ? AW'(back_sum - (AW+1)'(DEPTH))
                                                 : AW'(back_sum);

  assign value_ext = 64'(value_i);

  always_comb begin
    front_d  = front_q;
    count_d  = count_q;
    halted_d = halted_q;
    status_d = deq_pkg::STS_OK;
    wr_en    = 1'b0;
    rd_en    = 1'b0;
    addr     = front_q;
    case (deq_pkg::deq_action_e'(action_i))
      deq_pkg::ACT_PUSH_FRONT: begin
        if (full) begin
          status_d = deq_pkg::STS_FULL;
        end else begin
          front_d = (front_q == '0) ? AW'(DEPTH - 1) : front_q - AW'(1);
          addr    = front_d;
          wr_en   = 1'b1;
          count_d = count_q + CW'(1);
        end
      end
      deq_pkg::ACT_PUSH_BACK: begin
        if (full) begin
          status_d = deq_pkg::STS_FULL;
        end else begin
          addr    = tail_pos;
          wr_en   = 1'b1;
          count_d = count_q + CW'(1);
        end
      end
      deq_pkg::ACT_POP_FRONT, deq_pkg::ACT_PEEK_FRONT: begin
        if (empty) begin
          status_d = deq_pkg::STS_EMPTY;
        end else begin
          status_d = deq_pkg::STS_ELEMENT;
          addr     = front_q;
          rd_en    = 1'b1;
          if (action_i == deq_pkg::ACT_POP_FRONT) begin
            front_d = (front_q == AW'(DEPTH - 1)) ? '0 : front_q + AW'(1);
            count_d = count_q - CW'(1);
          end
        end
      end
      deq_pkg::ACT_POP_BACK, deq_pkg::ACT_PEEK_BACK: begin
        if (empty) begin
          status_d = deq_pkg::STS_EMPTY;
        end else begin
          status_d = deq_pkg::STS_ELEMENT;
          addr     = back_pos;
          rd_en    = 1'b1;
          if (action_i == deq_pkg::ACT_POP_BACK) begin
            count_d = count_q - CW'(1);
          end
        end
      end
      deq_pkg::ACT_CLEAR: begin
        front_d = '0;
        count_d = '0;
      end
      default: begin
        status_d = deq_pkg::STS_GOODBYE;
        halted_d = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q  <= '0;
      count_q  <= '0;
      halted_q <= 1'b0;
    end else if (cmd_i.exec) begin
      front_q  <= front_d;
      count_q  <= count_d;
      halted_q <= halted_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && wr_en) begin
      mem_q[addr] <= value_ext[DATA_WIDTH-1:0];
    end
    if (cmd_i.exec && rd_en) begin
      rd_data_q <= mem_q[addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      status_q <= status_d;
    end
  end

  assign rd_ext    = 64'(rd_data_q);
  assign status_o  = status_q;
  assign element_o = (status_q == deq_pkg::STS_ELEMENT) ? rd_ext[deq_pkg::FieldWidth-1:0]
                                                        : '0;
  assign stat_o.halted = halted_q;

endmodule
